// ----- rtl/tqas_pkg.sv -----
// Shared types and constants of the texture quad average sampler.
// Holds the command and result item structs, register indexes and mode codes.
// Depends on nothing; the top level, tqas_addr and the testbench refer to it by scoped names.
package tqas_pkg;

	localparam int COORD_W   = 17;
	localparam int ADDR_W    = 16;
	localparam int CHAN_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	// Q1.16 value of 1.0; coordinates above it saturate to it.
	localparam logic [COORD_W-1:0] Q_ONE = 17'h10000;

	// Command modes.
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Texture kinds.
	localparam logic KIND_COLOR  = 1'b0;
	localparam logic KIND_SCALAR = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_KIND   = 2'd2;

	localparam logic [CFG_DAT_W-1:0] SIZE_RESET = 9'd256;

	typedef struct packed {
		logic               mode;
		logic [ADDR_W-1:0]  texel_address;
		logic [CHAN_W-1:0]  channel_red;
		logic [CHAN_W-1:0]  channel_green;
		logic [CHAN_W-1:0]  channel_blue;
		logic [COORD_W-1:0] coord_u;
		logic [COORD_W-1:0] coord_v;
	} cmd_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] avg_red;
		logic [CHAN_W-1:0] avg_green;
		logic [CHAN_W-1:0] avg_blue;
	} res_item_t;

endpackage

// ----- rtl/texture_quad_average_sampler.sv -----
// Top level of the texture quad average sampler: configuration registers,
// four texel store copies, and the averaging stage. Uses tqas_pkg, tqas_addr
// and tqas_ram.
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall  tqas_pkg::cmd_item_t
//   res      out        res_valid / res_stall  tqas_pkg::res_item_t
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The block takes one item in every cycle unless it stalls the input. A sample's
// result is registered through the address stages, the store and stage five; a
// write item leaves no result.
// The four neighbor reads of a sample are served together by four copies of
// the texel store, each a single-port memory; every write goes to all four copies.
// Reset clears the valid bits and loads the registers (256 x 256, color); the store
// itself is not cleared and there is no clearing pass.
// A stall on res freezes only the stages that are full, so empty stages keep filling.
module texture_quad_average_sampler #(
	parameter int MAX_WIDTH    = 256,
	parameter int MAX_HEIGHT   = 256,
	parameter int CHANNEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  tqas_pkg::cmd_item_t                 cmd,
	output logic                                res_valid,
	input  logic                                res_stall,
	output tqas_pkg::res_item_t                 res,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tqas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tqas_pkg::CFG_DAT_W-1:0]      cfg_data
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CB    = CHANNEL_BITS;
	localparam int DW    = 3 * CB;
	localparam int SW    = CB + 2;

	// Configuration registers. The user sends writes only while the block is idle.
	logic [tqas_pkg::CFG_DAT_W-1:0] width_q, height_q;
	logic                           kind_q;
	logic [WW-1:0]                  width_eff;
	logic [HW-1:0]                  height_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tqas_pkg::SIZE_RESET;
			height_q <= tqas_pkg::SIZE_RESET;
			kind_q   <= tqas_pkg::KIND_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tqas_pkg::REG_TEXTURE_WIDTH:  width_q  <= cfg_data;
				tqas_pkg::REG_TEXTURE_HEIGHT: height_q <= cfg_data;
				tqas_pkg::REG_TEXTURE_KIND:   kind_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The sizes in use are clamped to 1..MAX; zero acts as one.
	always_comb begin
		if (width_q == '0) begin
			width_eff = WW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			height_eff = HW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			height_eff = HW'(MAX_HEIGHT);
		end else begin
			height_eff = HW'(height_q);
		end
	end

	// Stages one to three: input register, coordinate scaling and the four
	// neighbor addresses (lower-left, lower-right, upper-left, upper-right).
	logic                valid_s3, wr_ok_s3, addr_ready, s4_ready;
	tqas_pkg::cmd_item_t item_s3;
	logic [AW-1:0]       addr_s3 [4];

	tqas_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid),
		.in_ready  (addr_ready),
		.in_item   (cmd),
		.width     (width_eff),
		.height    (height_eff),
		.valid_s3  (valid_s3),
		.out_ready (s4_ready),
		.item_s3   (item_s3),
		.addr_s3   (addr_s3),
		.wr_ok_s3  (wr_ok_s3)
	);

	assign cmd_stall = !addr_ready;

	// Stage four: the store access. A write updates all four copies as it passes
	// from stage three to four, in item order with the samples, so a sample always
	// sees every write accepted before it. Only samples go on past this stage.
	logic          valid_s4, valid_s5;
	logic          s5_ready;
	logic          load_s4, is_sample_s3, mem_en;
	logic [DW-1:0] wdata;
	logic [DW-1:0] rd_data [4];

	assign s5_ready     = !valid_s5 || !res_stall;
	assign s4_ready     = !valid_s4 || s5_ready;
	assign load_s4      = valid_s3 && s4_ready;
	assign is_sample_s3 = (item_s3.mode == tqas_pkg::MODE_SAMPLE);
	assign mem_en       = load_s4 && (is_sample_s3 || wr_ok_s3);
	assign wdata        = {CB'(item_s3.channel_blue), CB'(item_s3.channel_green),
	                       CB'(item_s3.channel_red)};

	for (genvar k = 0; k < 4; k++) begin : g_copy
		tqas_ram #(
			.DEPTH (DEPTH),
			.DW    (DW)
		) u_ram (
			.clk   (clk),
			.en    (mem_en),
			.we    (!is_sample_s3),
			.addr  (addr_s3[k]),
			.wdata (wdata),
			.rdata (rd_data[k])
		);
	end

	// Stage five: per-channel sum of the four texels, truncated to a quarter.
	// In scalar kind only the first channel carries data.
	tqas_pkg::res_item_t res_s5;
	logic [SW-1:0]       sum [3];
	logic [tqas_pkg::CHAN_W-1:0] avg [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = '0;
			for (int k = 0; k < 4; k++) begin
				sum[c] = sum[c] + SW'(rd_data[k][c*CB +: CB]);
			end
			avg[c] = tqas_pkg::CHAN_W'(sum[c] >> 2);
			if (kind_q == tqas_pkg::KIND_SCALAR && c != 0) begin
				avg[c] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (s4_ready) valid_s4 <= valid_s3 && is_sample_s3;
			if (s5_ready) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (s5_ready) begin
			res_s5.avg_red   <= avg[0];
			res_s5.avg_green <= avg[1];
			res_s5.avg_blue  <= avg[2];
		end
	end

	assign res_valid = valid_s5;
	assign res       = res_s5;

	// The input stalls only when every stage from three to the output is full.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s3 && valid_s4 && valid_s5 && res_stall))
		else $error("input stalled with a free stage in the pipeline");

	// Read data of a held stage-four item must not be overwritten.
	a_rd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !s4_ready) |=> (valid_s4 && $stable(rd_data[0]) && $stable(rd_data[3])))
		else $error("store read data changed under a stalled item");

	// A new result comes only from an item that sat in stage four.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(valid_s4))
		else $error("result appeared without a sample in stage four");

endmodule

// ----- rtl/tqas_ram.sv -----
// Single-port synchronous texel memory with a registered read port.
// One access per cycle, either a write or a read; used four times by the top level.
// Depends on nothing outside this file.
module tqas_ram #(
	parameter int DEPTH = 65536,
	parameter int DW    = 48,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tqas_addr.sv -----
// Address pipeline of the sampler: input register, coordinate scaling and
// neighbor address generation in three stages. Uses tqas_pkg for the item type.
module tqas_addr #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	localparam int WW    = $clog2(MAX_WIDTH + 1),
	localparam int HW    = $clog2(MAX_HEIGHT + 1),
	localparam int XW    = $clog2(MAX_WIDTH),
	localparam int YW    = $clog2(MAX_HEIGHT),
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tqas_pkg::cmd_item_t   in_item,
	input  logic [WW-1:0]         width,
	input  logic [HW-1:0]         height,
	output logic                  valid_s3,
	input  logic                  out_ready,
	output tqas_pkg::cmd_item_t   item_s3,
	output logic [AW-1:0]         addr_s3 [4],
	output logic                  wr_ok_s3
);

	localparam int UW = tqas_pkg::COORD_W;
	localparam int MUW = WW + UW;
	localparam int MVW = HW + UW;
	localparam int PW  = YW + WW;

	logic valid_s1, valid_s2;
	logic ready_s1, ready_s2, ready_s3;

	tqas_pkg::cmd_item_t item_s1, item_s2;
	logic [UW-1:0] cu_s1, cv_s1;
	logic [XW-1:0] left_s2;
	logic [YW-1:0] lower_s2;

	logic [UW-1:0]  cu_sat, cv_sat;
	logic [MUW-1:0] prod_u;
	logic [MVW-1:0] prod_v;
	logic [WW-1:0]  next_col, right;
	logic [HW-1:0]  next_row, upper;
	logic [PW-1:0]  base_lo, base_up;
	logic [AW-1:0]  idx [4];
	logic           wr_ok;

	// A stage takes a new item when it is empty or its item moves on.
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign cu_sat = (in_item.coord_u > tqas_pkg::Q_ONE) ? tqas_pkg::Q_ONE : in_item.coord_u;
	assign cv_sat = (in_item.coord_v > tqas_pkg::Q_ONE) ? tqas_pkg::Q_ONE : in_item.coord_v;

	assign prod_u = MUW'(width - WW'(1)) * MUW'(cu_s1);
	assign prod_v = MVW'(height - HW'(1)) * MVW'(cv_s1);

	// Right and upper neighbors wrap to zero at the texture edge.
	always_comb begin
		next_col = WW'(left_s2) + WW'(1);
		next_row = HW'(lower_s2) + HW'(1);
		right    = (next_col >= width) ? '0 : next_col;
		upper    = (next_row >= height) ? '0 : next_row;
		base_lo  = PW'(lower_s2) * PW'(width);
		base_up  = PW'(upper) * PW'(width);
		idx[0]   = AW'(base_lo + PW'(left_s2));
		idx[1]   = AW'(base_lo + PW'(right));
		idx[2]   = AW'(base_up + PW'(left_s2));
		idx[3]   = AW'(base_up + PW'(right));
		wr_ok    = (32'(item_s2.texel_address) < 32'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			item_s1 <= in_item;
			cu_s1   <= cu_sat;
			cv_s1   <= cv_sat;
		end
		if (ready_s2) begin
			item_s2  <= item_s1;
			left_s2  <= XW'(prod_u >> 16);
			lower_s2 <= YW'(prod_v >> 16);
		end
		if (ready_s3) begin
			item_s3  <= item_s2;
			wr_ok_s3 <= wr_ok;
			for (int k = 0; k < 4; k++) begin
				addr_s3[k] <= (item_s2.mode == tqas_pkg::MODE_SAMPLE) ?
				              idx[k] : AW'(item_s2.texel_address);
			end
		end
	end

endmodule

// ----- tb/sv/tb_texture_quad_average_sampler.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for texture_quad_average_sampler: a directed table, then random
// phases of texel writes and samples under several idling patterns and texture setups.
// Depends on tqas_pkg and the block's RTL only.
module tb_texture_quad_average_sampler;

	// Store geometry and channel width of the instance under test.
	localparam int TEX_MAX_W    = 256;
	localparam int TEX_MAX_H    = 256;
	localparam int TEX_CHAN_W   = 16;
	localparam int STORE_DEPTH  = TEX_MAX_W * TEX_MAX_H;

	typedef logic [tqas_pkg::CHAN_W-1:0]    chan_t;
	typedef logic [tqas_pkg::ADDR_W-1:0]    addr_t;
	typedef logic [tqas_pkg::COORD_W-1:0]   coord_t;
	typedef logic [tqas_pkg::CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [tqas_pkg::CFG_DAT_W-1:0] cfg_data_t;

	// Register index that the block does not implement; writes to it must be ignored.
	localparam cfg_index_t REG_SPARE = 2'd3;

	// A write leaves no result, so these quiet cycles let every write land before
	// the setup changes.
	localparam int QUIET_CYCLES     = 12;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int PHASES           = 8;
	localparam int ITEMS_PER_PHASE  = 185;
	localparam int MAX_REPORTS      = 10;

	typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_t;

	// One row of the directed table: either an item (with an optional hand-typed
	// result) or a new texture setup applied while the block is idle.
	typedef struct {
		row_kind_t            kind;
		tqas_pkg::cmd_item_t  item;
		logic                 typed;
		tqas_pkg::res_item_t  want;
		cfg_data_t            width;
		cfg_data_t            height;
		logic                 tex_kind;
	} directed_row_t;

	// Four store addresses around a sample point: lower-left, lower-right,
	// upper-left, upper-right.
	typedef logic [3:0][tqas_pkg::ADDR_W-1:0] quad_addr_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	tqas_pkg::cmd_item_t cmd = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	tqas_pkg::res_item_t res;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_index_t          cfg_index = '0;
	cfg_data_t           cfg_data = '0;

	// Shadow copy of the texture setup and of the texel store.
	cfg_data_t shadow_width  = tqas_pkg::SIZE_RESET;
	cfg_data_t shadow_height = tqas_pkg::SIZE_RESET;
	logic      shadow_kind   = tqas_pkg::KIND_COLOR;
	chan_t     texel_red   [0:STORE_DEPTH-1];
	chan_t     texel_green [0:STORE_DEPTH-1];
	chan_t     texel_blue  [0:STORE_DEPTH-1];
	bit        texel_written [0:STORE_DEPTH-1];

	tqas_pkg::res_item_t pending_averages [$];
	directed_row_t       directed_rows [$];

	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;
	int long_hold_left = 0;
	int quiet_streak   = 0;
	int items_sent     = 0;

	texture_quad_average_sampler #(
		.MAX_WIDTH   (TEX_MAX_W),
		.MAX_HEIGHT  (TEX_MAX_H),
		.CHANNEL_BITS(TEX_CHAN_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Size registers act as 1 when zero and saturate at the store's dimension.
	function automatic int unsigned usable_size(cfg_data_t r, int unsigned limit);
		if (r == 0)
			return 1;
		if (32'(r) > limit)
			return limit;
		return 32'(r);
	endfunction

	// Column or row of the lower-left texel: floor((size-1) * coord), with the
	// Q1.16 coordinate saturated to one.
	function automatic int unsigned lower_cell(int unsigned size, coord_t coord);
		int unsigned c;
		c = 32'((coord > tqas_pkg::Q_ONE) ? tqas_pkg::Q_ONE : coord);
		return ((size - 1) * c) >> 16;
	endfunction

	// Store addresses of the 2x2 neighborhood; the right column and the upper
	// row wrap to zero at the texture edge.
	function automatic quad_addr_t neighbor_texels(coord_t u, coord_t v);
		int unsigned w, h, left, right, lower, upper;
		quad_addr_t q;
		w = usable_size(shadow_width, TEX_MAX_W);
		h = usable_size(shadow_height, TEX_MAX_H);
		left  = lower_cell(w, u);
		lower = lower_cell(h, v);
		right = (left + 1 >= w) ? 0 : left + 1;
		upper = (lower + 1 >= h) ? 0 : lower + 1;
		q[0] = addr_t'(lower * w + left);
		q[1] = addr_t'(lower * w + right);
		q[2] = addr_t'(upper * w + left);
		q[3] = addr_t'(upper * w + right);
		return q;
	endfunction

	// Truncated per-channel mean of the four neighbors. In scalar kind only the
	// first channel carries data and the other two read as zero.
	function automatic tqas_pkg::res_item_t average_quad(tqas_pkg::cmd_item_t item);
		quad_addr_t q;
		int unsigned sum_r, sum_g, sum_b;
		tqas_pkg::res_item_t avg;
		q = neighbor_texels(item.coord_u, item.coord_v);
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		for (int k = 0; k < 4; k++) begin
			sum_r += 32'(texel_red[q[k]]);
			sum_g += 32'(texel_green[q[k]]);
			sum_b += 32'(texel_blue[q[k]]);
		end
		avg.avg_red   = chan_t'(sum_r >> 2);
		avg.avg_green = (shadow_kind == tqas_pkg::KIND_SCALAR) ? '0 : chan_t'(sum_g >> 2);
		avg.avg_blue  = (shadow_kind == tqas_pkg::KIND_SCALAR) ? '0 : chan_t'(sum_b >> 2);
		return avg;
	endfunction

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// Offers one item, holding it until accepted, then updates the shadow store or
	// queues the expected average. Valid is only lowered when the sender idles,
	// never between two back-to-back items.
	task automatic push_item(input tqas_pkg::cmd_item_t item, input logic typed,
			input tqas_pkg::res_item_t want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do @(posedge clk); while (cmd_stall);
		items_sent++;
		if (item.mode == tqas_pkg::MODE_WRITE) begin
			texel_red[item.texel_address]     = item.channel_red;
			texel_green[item.texel_address]   = item.channel_green;
			texel_blue[item.texel_address]    = item.channel_blue;
			texel_written[item.texel_address] = 1'b1;
		end else begin
			pending_averages.push_back(typed ? want : average_quad(item));
		end
	endtask

	// Sender stops, every queued average comes back, and in-flight writes settle.
	task automatic wait_for_quiet();
		cmd_valid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers plus the unimplemented index, back to back.
	task automatic program_texture(input cfg_data_t w, input cfg_data_t h, input logic k);
		cfg_index_t idx_list [4];
		cfg_data_t  data_list [4];
		idx_list[0]  = tqas_pkg::REG_TEXTURE_WIDTH;
		data_list[0] = w;
		idx_list[1]  = REG_SPARE;
		data_list[1] = cfg_data_t'($urandom);
		idx_list[2]  = tqas_pkg::REG_TEXTURE_HEIGHT;
		data_list[2] = h;
		idx_list[3]  = tqas_pkg::REG_TEXTURE_KIND;
		data_list[3] = {{(tqas_pkg::CFG_DAT_W-1){1'b0}}, k};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= data_list[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[i])
				tqas_pkg::REG_TEXTURE_WIDTH:  shadow_width  = data_list[i];
				tqas_pkg::REG_TEXTURE_HEIGHT: shadow_height = data_list[i];
				tqas_pkg::REG_TEXTURE_KIND:   shadow_kind   = data_list[i][0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Channel values lean toward the extremes so that sums overflow the 16-bit range.
	function automatic chan_t pick_channel();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom);
		endcase
	endfunction

	// Coordinates: exact edges, just below one, saturating values, or anywhere in [0, 1].
	function automatic coord_t pick_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return tqas_pkg::Q_ONE;
			2: return tqas_pkg::Q_ONE - 1;
			3: return coord_t'($urandom_range(tqas_pkg::Q_ONE + 1,
				(1 << tqas_pkg::COORD_W) - 1));
			default: return coord_t'($urandom_range(0, tqas_pkg::Q_ONE));
		endcase
	endfunction

	task automatic send_texel_write(input addr_t addr);
		tqas_pkg::cmd_item_t c;
		c.mode          = tqas_pkg::MODE_WRITE;
		c.texel_address = addr;
		c.channel_red   = pick_channel();
		c.channel_green = pick_channel();
		c.channel_blue  = pick_channel();
		c.coord_u       = coord_t'($urandom);
		c.coord_v       = coord_t'($urandom);
		push_item(c, 1'b0, '0);
	endtask

	// Any neighbor that has never been written is filled first, so no sample
	// ever reads an undefined store entry.
	task automatic send_random_sample();
		tqas_pkg::cmd_item_t c;
		quad_addr_t q;
		c.mode          = tqas_pkg::MODE_SAMPLE;
		c.texel_address = addr_t'($urandom);
		c.channel_red   = chan_t'($urandom);
		c.channel_green = chan_t'($urandom);
		c.channel_blue  = chan_t'($urandom);
		c.coord_u       = pick_coord();
		c.coord_v       = pick_coord();
		q = neighbor_texels(c.coord_u, c.coord_v);
		for (int k = 0; k < 4; k++)
			if (!texel_written[q[k]])
				send_texel_write(q[k]);
		push_item(c, 1'b0, '0);
	endtask

	function automatic void add_write(input addr_t addr, input chan_t r, input chan_t g,
			input chan_t b);
		directed_row_t row;
		row.kind = ROW_ITEM;
		row.item = '0;
		row.item.mode          = tqas_pkg::MODE_WRITE;
		row.item.texel_address = addr;
		row.item.channel_red   = r;
		row.item.channel_green = g;
		row.item.channel_blue  = b;
		row.typed = 1'b0;
		row.want  = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_sample(input coord_t u, input coord_t v, input logic typed,
			input tqas_pkg::res_item_t want);
		directed_row_t row;
		row.kind = ROW_ITEM;
		row.item = '0;
		row.item.mode    = tqas_pkg::MODE_SAMPLE;
		row.item.coord_u = u;
		row.item.coord_v = v;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_setup(input cfg_data_t w, input cfg_data_t h, input logic k);
		directed_row_t row;
		row.kind     = ROW_SETUP;
		row.item     = '0;
		row.typed    = 1'b0;
		row.want     = '0;
		row.width    = w;
		row.height   = h;
		row.tex_kind = k;
		directed_rows.push_back(row);
	endfunction

	// Receiver: a long hold-off when one is requested, otherwise random stalls at
	// the rate of the current phase.
	always @(posedge clk) begin
		if (long_hold_left > 0) begin
			res_stall <= 1'b1;
			long_hold_left--;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every accepted result is matched field by field against the oldest
	// queued average.
	always @(posedge clk) begin : check_results
		tqas_pkg::res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_averages.size() == 0) begin
				note_mismatch($sformatf("result %h arrived with nothing expected", res));
			end else begin
				want = pending_averages.pop_front();
				if (res.avg_red !== want.avg_red)
					note_mismatch($sformatf("avg_red expected %h, got %h",
						want.avg_red, res.avg_red));
				if (res.avg_green !== want.avg_green)
					note_mismatch($sformatf("avg_green expected %h, got %h",
						want.avg_green, res.avg_green));
				if (res.avg_blue !== want.avg_blue)
					note_mismatch($sformatf("avg_blue expected %h, got %h",
						want.avg_blue, res.avg_blue));
			end
		end
	end

	// Watchdog: ends the run when no channel moves an item for too long. The
	// limit covers the long receiver hold-off several times over.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet_streak = 0;
		else
			quiet_streak++;
		if (quiet_streak >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		cfg_data_t   w, h;
		logic        k;
		int unsigned region;
		int          phase_start;
		bit          paused;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset setup of 256 x 256 color first. Corner texels
		// hold all-ones or zero so the averages of the extremes can be typed in.
		add_write(16'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF);
		add_write(16'd1,   16'hFFFF, 16'h0000, 16'h0000);
		add_write(16'd256, 16'hFFFF, 16'h0000, 16'hFFFF);
		add_write(16'd257, 16'hFFFF, 16'hFFFF, 16'h0000);
		add_sample(17'd0, 17'd0, 1'b1, {16'hFFFF, 16'h7FFF, 16'h7FFF});
		add_write(16'd255,   16'h0000, 16'h0000, 16'h0000);
		add_write(16'd65280, 16'h0000, 16'h0000, 16'h0000);
		add_write(16'hFFFF,  16'h0000, 16'h0000, 16'h0000);
		// Both coordinates saturate: the last column and row, with the right and
		// upper neighbors wrapping back to zero.
		add_sample(17'h1FFFF, 17'h1FFFF, 1'b1, {16'h3FFF, 16'h3FFF, 16'h3FFF});
		add_sample(tqas_pkg::Q_ONE, tqas_pkg::Q_ONE, 1'b1, {16'h3FFF, 16'h3FFF, 16'h3FFF});
		add_write(16'd65281, 16'h1234, 16'h5678, 16'h9ABC);
		add_sample(17'd0, 17'h1FFFF, 1'b0, '0);
		add_write(16'd511, 16'hAAAA, 16'h5555, 16'h8001);
		add_sample(17'h1FFFF, 17'd0, 1'b0, '0);
		add_write(16'd254, 16'h7FFF, 16'h8000, 16'h0001);
		add_write(16'd510, 16'hFFFE, 16'h0003, 16'hC3C3);
		// Just below one still lands on the second to last column.
		add_sample(tqas_pkg::Q_ONE - 1, 17'd0, 1'b0, '0);
		// Zero sizes act as a 1 x 1 texture: every neighbor is texel zero, and in
		// scalar kind only the first channel is averaged.
		add_setup(9'd0, 9'd0, tqas_pkg::KIND_SCALAR);
		add_sample(17'h1FFFF, 17'd0, 1'b1, {16'hFFFF, 16'h0000, 16'h0000});
		// Oversized registers clamp back to the full 256 x 256 store.
		add_setup(9'd511, 9'd300, tqas_pkg::KIND_COLOR);
		add_sample(17'd0, 17'd0, 1'b1, {16'hFFFF, 16'h7FFF, 16'h7FFF});
		add_sample(17'd1, 17'd1, 1'b1, {16'hFFFF, 16'h7FFF, 16'h7FFF});

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_SETUP) begin
				wait_for_quiet();
				program_texture(directed_rows[i].width, directed_rows[i].height,
					directed_rows[i].tex_kind);
			end else begin
				push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// Random phases. Each one starts idle with a new setup, from the extremes
		// to small odd shapes; the idling pattern cycles through four settings.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin w = 9'd256; h = 9'd256; k = tqas_pkg::KIND_COLOR; end
				1: begin w = 9'd1; h = 9'd1; k = tqas_pkg::KIND_SCALAR; end
				2: begin w = 9'd2; h = 9'd3; k = tqas_pkg::KIND_COLOR; end
				3: begin
					w = cfg_data_t'($urandom_range(1, 16));
					h = cfg_data_t'($urandom_range(1, 16));
					k = tqas_pkg::KIND_SCALAR;
				end
				4: begin w = 9'd0; h = 9'd300; k = tqas_pkg::KIND_COLOR; end
				5: begin w = 9'd256; h = 9'd1; k = tqas_pkg::KIND_SCALAR; end
				6: begin
					w = cfg_data_t'($urandom_range(1, 40));
					h = cfg_data_t'($urandom_range(1, 40));
					k = tqas_pkg::KIND_COLOR;
				end
				default: begin
					w = cfg_data_t'($urandom_range(0, 511));
					h = cfg_data_t'($urandom_range(0, 511));
					k = 1'($urandom_range(0, 1));
				end
			endcase
			wait_for_quiet();
			program_texture(w, h, k);
			region = usable_size(shadow_width, TEX_MAX_W) * usable_size(shadow_height, TEX_MAX_H);

			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 49; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 49; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase

			// The receiver holds off for a long stretch while items keep coming, so
			// the pipeline fills and the block has to stall its input.
			if (phase == 0)
				long_hold_left = LONG_HOLD_CYCLES;

			// Each phase sends at least ITEMS_PER_PHASE items, the filling writes included.
			phase_start = items_sent;
			paused      = 1'b0;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				// Midway through phase 1, the sender waits for every outstanding average.
				if (phase == 1 && !paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
					wait_for_quiet();
					paused = 1'b1;
				end
				case ($urandom_range(9))
					0, 1: send_texel_write(addr_t'($urandom_range(0, region - 1)));
					2:    send_texel_write(addr_t'($urandom));
					default: send_random_sample();
				endcase
			end
		end

		wait_for_quiet();
		if (mismatch_count == 0 && pending_averages.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
